@@ rtl/tbsw_pkg.sv @@
// shared constants and types of the three button selector
`default_nettype none

package tbsw_pkg;

   // widths of the word fields and registers
   localparam int unsigned TimeW     = 32;
   localparam int unsigned MsW       = 16;
   localparam int unsigned WindowW   = 20;
   localparam int unsigned PeriodW   = 10;
   localparam int unsigned CsrAddrW  = 3;
   localparam int unsigned CsrDataW  = 20;
   localparam int unsigned ReqDataW  = 8;
   localparam int unsigned RspDataW  = 8;
   localparam int unsigned RowOutW   = 3;
   localparam int unsigned DivCntW   = 5;

   localparam int unsigned RowCountDefault = 8;

   // register reset values
   localparam logic [MsW-1:0]     DebounceReset = 16'd30;
   localparam logic [MsW-1:0]     GuardReset    = 16'd150;
   localparam logic [MsW-1:0]     LongReset     = 16'd2000;
   localparam logic [MsW-1:0]     BlinkReset    = 16'd250;
   localparam logic [WindowW-1:0] WindowReset   = 20'd10000;
   localparam logic [PeriodW-1:0] PeriodReset   = 10'd50;

   typedef enum logic [CsrAddrW-1:0] {
      CSR_DEBOUNCE = 3'd0,
      CSR_GUARD    = 3'd1,
      CSR_LONG     = 3'd2,
      CSR_BLINK    = 3'd3,
      CSR_WINDOW   = 3'd4,
      CSR_PERIOD   = 3'd5
   } csr_idx_type;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_EDGE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      BTN_PLUS  = 2'd0,
      BTN_MINUS = 2'd1,
      BTN_SET   = 2'd2
   } button_type;

   // wrapping elapsed-time test
   function automatic logic elapsed(input logic [TimeW-1:0] now,
                                    input logic [TimeW-1:0] then_t,
                                    input logic [TimeW-1:0] lim);
      logic [TimeW-1:0] diff;
      diff = now - then_t;
      return diff >= lim;
   endfunction

endpackage

`default_nettype wire

@@ rtl/three_button_selector_with_window.sv @@
// top level of the three button selector with its selection window
//
// usage: each req_ word is one millisecond tick (req_tuser = 0) or one button
// edge event (req_tuser = 1) of PLUS, MINUS or SET. every accepted word gives
// exactly one rsp_ word with the selected row, window and led state after the
// word, plus one-shot toggle and error-clear requests.
// each word passes the input register, then the update logic feeding the state and
// the rsp output register. throughput: one word per clock while rsp_tready is high and
// no remainder pass runs; the input register refills in the same cycle the output
// register is taken, so back-to-back words run at full rate.
// when the receiver stalls, the output register holds its word and the input
// register holds one more word, after which req_tready drops.
// csr_ writes set the six timing registers. a write of the check period starts
// a remainder pass (clock_ms mod check period, one bit a cycle);
// req_tready stays low during that pass.
// reset (synchronous, active high) returns all timers, the window and the row
// to zero, the registers to their defaults, and empties both word registers.
`default_nettype none

module three_button_selector_with_window #(
   parameter int unsigned ROW_COUNT = tbsw_pkg::RowCountDefault
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request words
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [tbsw_pkg::ReqDataW-1:0]   req_tdata,  // button[1:0], edge_fall[2], edge_rise[3]
   input  wire logic                            req_tuser,  // cmd
   // response words
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [tbsw_pkg::RspDataW-1:0]   rsp_tdata,  // row[2:0], window_open[3], led_on[4],
                                                            // toggle_request[5], clear_error[6]
   // register writes
   input  wire logic                            csr_we,
   input  wire logic [tbsw_pkg::CsrAddrW-1:0]   csr_addr,
   input  wire logic [tbsw_pkg::CsrDataW-1:0]   csr_wdata
);

   localparam int unsigned RowW = $clog2(ROW_COUNT);
   localparam logic [RowW-1:0] RowMax = RowW'(ROW_COUNT - 1);
   localparam int unsigned TW = tbsw_pkg::TimeW;
   localparam int unsigned PW = tbsw_pkg::PeriodW;

   // configuration registers
   logic [tbsw_pkg::MsW-1:0]     debounce_ff, guard_ff, long_ff, blink_ff;
   logic [tbsw_pkg::WindowW-1:0] window_ff;
   logic [PW-1:0]                period_ff;

   // input register
   logic       in_valid_ff;
   logic       in_cmd_ff;
   logic [1:0] in_button_ff;
   logic       in_fall_ff, in_rise_ff;

   // output register
   logic                          out_valid_ff;
   logic [tbsw_pkg::RspDataW-1:0] out_data_ff, out_data_in;

   // block state
   logic [TW-1:0]   clock_ms_ff, clock_ms_in;
   logic [TW-1:0]   plus_edge_ff, plus_edge_in, plus_act_ff, plus_act_in;
   logic [TW-1:0]   minus_edge_ff, minus_edge_in, minus_act_ff, minus_act_in;
   logic [TW-1:0]   set_edge_ff, set_edge_in, set_press_ff, set_press_in;
   logic            set_held_ff, set_held_in, long_done_ff, long_done_in;
   logic            long_armed_ff, long_armed_in;
   logic            sel_open_ff, sel_open_in;
   logic [TW-1:0]   activity_ff, activity_in, blink_time_ff, blink_time_in;
   logic            blink_phase_ff, blink_phase_in;
   logic [RowW-1:0] sel_row_ff, sel_row_in;

   // clock_ms mod check period, also the partial remainder of the divider
   logic [PW-1:0]                chk_rem_ff, chk_rem_in;
   logic                         div_busy_ff;
   logic [tbsw_pkg::DivCntW-1:0] div_cnt_ff;
   logic [TW-1:0]                div_num_ff;

   logic          advance;
   logic [PW-1:0] per_eff;
   logic [PW:0]   div_trial, div_sub;

   assign per_eff = (period_ff == '0) ? PW'(1) : period_ff;

   // input register moves on when the output register is free or being taken
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !div_busy_ff && (!in_valid_ff || advance);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // one restoring division step per cycle
   assign div_trial = {chk_rem_ff, div_num_ff[TW-1]};
   assign div_sub   = (div_trial >= {1'b0, per_eff}) ? div_trial - {1'b0, per_eff} : div_trial;

   // update logic for the word in the input register
   always_comb begin
      logic [TW-1:0]     now, clk_next, et, at;
      logic [PW-1:0]     rem_inc;
      logic              toggle, clr, is_plus;
      logic [RowW+2:0]   row_ext;

      clock_ms_in    = clock_ms_ff;
      plus_edge_in   = plus_edge_ff;
      plus_act_in    = plus_act_ff;
      minus_edge_in  = minus_edge_ff;
      minus_act_in   = minus_act_ff;
      set_edge_in    = set_edge_ff;
      set_press_in   = set_press_ff;
      set_held_in    = set_held_ff;
      long_done_in   = long_done_ff;
      long_armed_in  = long_armed_ff;
      sel_open_in    = sel_open_ff;
      activity_in    = activity_ff;
      blink_time_in  = blink_time_ff;
      blink_phase_in = blink_phase_ff;
      sel_row_in     = sel_row_ff;
      chk_rem_in     = chk_rem_ff;
      toggle         = 1'b0;
      clr            = 1'b0;
      now            = clock_ms_ff;
      clk_next       = clock_ms_ff + TW'(1);
      rem_inc        = chk_rem_ff + PW'(1);
      is_plus        = (in_button_ff == tbsw_pkg::BTN_PLUS);
      et             = is_plus ? plus_edge_ff : minus_edge_ff;
      at             = is_plus ? plus_act_ff : minus_act_ff;

      if (in_cmd_ff == tbsw_pkg::CMD_TICK) begin
         clock_ms_in = clk_next;
         // long press fires once the hold time is reached
         if (long_armed_ff &&
             tbsw_pkg::elapsed(clk_next, set_press_ff, TW'(long_ff))) begin
            long_armed_in = 1'b0;
            if (set_held_ff && !long_done_ff) begin
               long_done_in = 1'b1;
               clr          = 1'b1;
            end
         end
         // running remainder, restarts when the clock wraps
         if (clk_next == '0 || rem_inc == per_eff) begin
            chk_rem_in = '0;
         end else begin
            chk_rem_in = rem_inc;
         end
         if (chk_rem_in == '0 && sel_open_ff) begin
            if (tbsw_pkg::elapsed(clk_next, blink_time_ff, TW'(blink_ff))) begin
               blink_time_in  = clk_next;
               blink_phase_in = !blink_phase_ff;
            end
            if (tbsw_pkg::elapsed(clk_next, activity_ff, TW'(window_ff))) begin
               sel_open_in = 1'b0;
            end
         end
      end else begin
         case (in_button_ff)
            tbsw_pkg::BTN_PLUS, tbsw_pkg::BTN_MINUS: begin
               if (in_fall_ff && tbsw_pkg::elapsed(now, et, TW'(debounce_ff))
                   && tbsw_pkg::elapsed(now, at, TW'(guard_ff))) begin
                  if (sel_open_ff) begin
                     if (is_plus) begin
                        sel_row_in = (sel_row_ff >= RowMax) ? '0 : sel_row_ff + RowW'(1);
                     end else begin
                        sel_row_in = (sel_row_ff == '0) ? RowMax : sel_row_ff - RowW'(1);
                     end
                  end else begin
                     sel_open_in    = 1'b1;
                     blink_phase_in = 1'b1;
                     blink_time_in  = now;
                  end
                  activity_in = now;
                  if (is_plus) begin
                     plus_act_in = now;
                  end else begin
                     minus_act_in = now;
                  end
               end
               if (in_fall_ff || in_rise_ff) begin
                  if (is_plus) begin
                     plus_edge_in = now;
                  end else begin
                     minus_edge_in = now;
                  end
               end
            end
            tbsw_pkg::BTN_SET: begin
               if (in_fall_ff) begin
                  if (tbsw_pkg::elapsed(now, set_edge_ff, TW'(debounce_ff)) && !set_held_ff) begin
                     set_held_in   = 1'b1;
                     long_done_in  = 1'b0;
                     set_press_in  = now;
                     set_edge_in   = now;
                     long_armed_in = 1'b1;
                  end
               end else if (in_rise_ff) begin
                  if (tbsw_pkg::elapsed(now, set_edge_ff, TW'(debounce_ff))) begin
                     set_edge_in = now;
                     if (set_held_ff) begin
                        long_armed_in = 1'b0;
                        set_held_in   = 1'b0;
                        long_done_in  = 1'b0;
                        // short press: open the window or ask for a toggle
                        if (!long_done_ff) begin
                           if (!sel_open_ff) begin
                              sel_open_in    = 1'b1;
                              blink_phase_in = 1'b1;
                              blink_time_in  = now;
                           end else begin
                              toggle = 1'b1;
                           end
                           activity_in = now;
                        end
                     end
                  end
               end
            end
            default: begin
               // unknown button is ignored
            end
         endcase
      end

      row_ext     = {3'b000, sel_row_in};
      out_data_in = {1'b0, clr, toggle, sel_open_in && blink_phase_in, sel_open_in,
                     row_ext[tbsw_pkg::RowOutW-1:0]};
   end

   // configuration registers and remainder pass
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= tbsw_pkg::DebounceReset;
         guard_ff    <= tbsw_pkg::GuardReset;
         long_ff     <= tbsw_pkg::LongReset;
         blink_ff    <= tbsw_pkg::BlinkReset;
         window_ff   <= tbsw_pkg::WindowReset;
         period_ff   <= tbsw_pkg::PeriodReset;
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
         div_num_ff  <= '0;
         chk_rem_ff  <= '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               tbsw_pkg::CSR_DEBOUNCE: debounce_ff <= csr_wdata[tbsw_pkg::MsW-1:0];
               tbsw_pkg::CSR_GUARD:    guard_ff    <= csr_wdata[tbsw_pkg::MsW-1:0];
               tbsw_pkg::CSR_LONG:     long_ff     <= csr_wdata[tbsw_pkg::MsW-1:0];
               tbsw_pkg::CSR_BLINK:    blink_ff    <= csr_wdata[tbsw_pkg::MsW-1:0];
               tbsw_pkg::CSR_WINDOW:   window_ff   <= csr_wdata[tbsw_pkg::WindowW-1:0];
               tbsw_pkg::CSR_PERIOD:   period_ff   <= csr_wdata[PW-1:0];
               default: begin
               end
            endcase
         end
         if (csr_we && csr_addr == tbsw_pkg::CSR_PERIOD) begin
            // new period: recompute clock_ms mod period from scratch
            div_busy_ff <= 1'b1;
            div_cnt_ff  <= '1;
            div_num_ff  <= clock_ms_ff;
            chk_rem_ff  <= '0;
         end else if (div_busy_ff) begin
            chk_rem_ff <= div_sub[PW-1:0];
            div_num_ff <= {div_num_ff[TW-2:0], 1'b0};
            div_cnt_ff <= div_cnt_ff - tbsw_pkg::DivCntW'(1);
            if (div_cnt_ff == '0) begin
               div_busy_ff <= 1'b0;
            end
         end else if (advance) begin
            chk_rem_ff <= chk_rem_in;
         end
      end
   end

   // word registers and block state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         clock_ms_ff    <= '0;
         plus_edge_ff   <= '0;
         plus_act_ff    <= '0;
         minus_edge_ff  <= '0;
         minus_act_ff   <= '0;
         set_edge_ff    <= '0;
         set_press_ff   <= '0;
         set_held_ff    <= 1'b0;
         long_done_ff   <= 1'b0;
         long_armed_ff  <= 1'b0;
         sel_open_ff    <= 1'b0;
         activity_ff    <= '0;
         blink_time_ff  <= '0;
         blink_phase_ff <= 1'b0;
         sel_row_ff     <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff  <= 1'b1;
            in_cmd_ff    <= req_tuser;
            in_button_ff <= req_tdata[1:0];
            in_fall_ff   <= req_tdata[2];
            in_rise_ff   <= req_tdata[3];
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff   <= 1'b1;
            out_data_ff    <= out_data_in;
            clock_ms_ff    <= clock_ms_in;
            plus_edge_ff   <= plus_edge_in;
            plus_act_ff    <= plus_act_in;
            minus_edge_ff  <= minus_edge_in;
            minus_act_ff   <= minus_act_in;
            set_edge_ff    <= set_edge_in;
            set_press_ff   <= set_press_in;
            set_held_ff    <= set_held_in;
            long_done_ff   <= long_done_in;
            long_armed_ff  <= long_armed_in;
            sel_open_ff    <= sel_open_in;
            activity_ff    <= activity_in;
            blink_time_ff  <= blink_time_in;
            blink_phase_ff <= blink_phase_in;
            sel_row_ff     <= sel_row_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

@@ tb/sv/tb_three_button_selector_with_window.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the three button selector with its selection window
module tb_three_button_selector_with_window;

   localparam int unsigned TW          = tbsw_pkg::TimeW;
   localparam int unsigned RowLast     = tbsw_pkg::RowCountDefault - 1;
   localparam int unsigned StuckLimit  = 1000;  // cycles with no word moving
   localparam int unsigned MaxReported = 10;
   localparam int unsigned HoldOffLen  = 80;    // long receiver stall, fills the block
   localparam int unsigned HoldOffAt   = 200;   // response count that triggers it
   localparam int unsigned ResetRows   = 4;     // directed rows run on reset timing
   localparam int unsigned PhaseCount  = 5;
   localparam logic [1:0]  BtnUnused   = 2'd3;  // no button behind this code

   localparam tbsw_pkg::cmd_type    CmdTick  = tbsw_pkg::CMD_TICK;
   localparam tbsw_pkg::cmd_type    CmdEdge  = tbsw_pkg::CMD_EDGE;
   localparam tbsw_pkg::button_type BtnPlus  = tbsw_pkg::BTN_PLUS;
   localparam tbsw_pkg::button_type BtnMinus = tbsw_pkg::BTN_MINUS;
   localparam tbsw_pkg::button_type BtnSet   = tbsw_pkg::BTN_SET;

   // one request word: cmd travels on tuser, the rest on tdata
   typedef struct packed {
      tbsw_pkg::cmd_type cmd;
      logic [1:0]        button;
      logic              fall;
      logic              rise;
   } btn_word_type;

   // one response word, fields as on rsp_tdata
   typedef struct packed {
      logic [2:0] row;
      logic       window_open;
      logic       led_on;
      logic       toggle_request;
      logic       clear_error;
   } status_word_type;

   typedef struct packed {
      btn_word_type w;
      logic         pinned;  // expected word typed in: idle status
   } script_row_type;

   typedef struct packed {
      logic [tbsw_pkg::MsW-1:0]     debounce;
      logic [tbsw_pkg::MsW-1:0]     guard;
      logic [tbsw_pkg::MsW-1:0]     long_press;
      logic [tbsw_pkg::MsW-1:0]     blink;
      logic [tbsw_pkg::WindowW-1:0] window;
      logic [tbsw_pkg::PeriodW-1:0] period;
   } timing_type;

   localparam status_word_type IdleStatus = '0;
   localparam btn_word_type    TickWord   = '{cmd: CmdTick, button: BtnPlus,
                                              fall: 1'b0, rise: 1'b0};

   // dut ports, all driven to known values from time zero
   logic                          clock;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [tbsw_pkg::ReqDataW-1:0] req_tdata  = '0;
   logic                          req_tuser  = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [tbsw_pkg::RspDataW-1:0] rsp_tdata;
   logic                          csr_we     = 1'b0;
   logic [tbsw_pkg::CsrAddrW-1:0] csr_addr   = '0;
   logic [tbsw_pkg::CsrDataW-1:0] csr_wdata  = '0;

   // selector state as predicted by the testbench
   logic [TW-1:0] now_ms, plus_edge_ms, plus_act_ms, minus_edge_ms, minus_act_ms;
   logic [TW-1:0] set_edge_ms, set_down_ms, activity_ms, blink_stamp_ms;
   logic          set_down, long_hit, long_pending, win_open, blink_on;
   logic [2:0]    cur_row;
   timing_type    timing;

   // responses still owed by the block, oldest first
   status_word_type expected_status_q[$];

   int  words_sent      = 0;
   int  results_seen    = 0;
   int  mismatches      = 0;
   int  settings_loaded = 0;
   int  toggles_due     = 0;
   int  clears_due      = 0;
   int  stuck_cycles    = 0;
   bit  steady_run      = 1'b0;  // no idling on either side

   three_button_selector_with_window dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // wrapping elapsed time, counts once it reaches the limit
   function automatic logic reached(input logic [TW-1:0] now_t,
                                    input logic [TW-1:0] then_t,
                                    input logic [TW-1:0] lim);
      logic [TW-1:0] diff;
      diff = now_t - then_t;
      return diff >= lim;
   endfunction

   // any activity keeps the window open; opening restarts the blink lit
   task automatic touch_window();
      if (!win_open) begin
         win_open       = 1'b1;
         blink_on       = 1'b1;
         blink_stamp_ms = now_ms;
      end
      activity_ms = now_ms;
   endtask

   // advance the predicted selector by one accepted word
   task automatic predict_selector_word(input btn_word_type w, output status_word_type s);
      logic [TW-1:0] per, edge_ms, act_ms, deb;
      logic          toggle, clear;
      toggle = 1'b0;
      clear  = 1'b0;
      deb    = TW'(timing.debounce);
      if (w.cmd == CmdTick) begin
         // zero period behaves as one
         per    = (timing.period == '0) ? 32'd1 : TW'(timing.period);
         now_ms = now_ms + 32'd1;
         if (long_pending && reached(now_ms, set_down_ms, TW'(timing.long_press))) begin
            long_pending = 1'b0;
            if (set_down && !long_hit) begin
               long_hit = 1'b1;
               clear    = 1'b1;
            end
         end
         // blink before timeout, only on a check tick with the window open
         if (now_ms % per == 0 && win_open) begin
            if (reached(now_ms, blink_stamp_ms, TW'(timing.blink))) begin
               blink_stamp_ms = now_ms;
               blink_on       = !blink_on;
            end
            if (reached(now_ms, activity_ms, TW'(timing.window)))
               win_open = 1'b0;
         end
      end else if (w.button == BtnPlus || w.button == BtnMinus) begin
         edge_ms = (w.button == BtnPlus) ? plus_edge_ms : minus_edge_ms;
         act_ms  = (w.button == BtnPlus) ? plus_act_ms  : minus_act_ms;
         // press first, then release when both edges come together
         if (w.fall) begin
            if (reached(now_ms, edge_ms, deb) && reached(now_ms, act_ms, TW'(timing.guard)))
            begin
               if (win_open) begin
                  if (w.button == BtnPlus)
                     cur_row = (cur_row == 3'(RowLast)) ? 3'd0 : cur_row + 3'd1;
                  else
                     cur_row = (cur_row == 3'd0) ? 3'(RowLast) : cur_row - 3'd1;
               end
               touch_window();
               act_ms = now_ms;
            end
            edge_ms = now_ms;
         end
         if (w.rise)
            edge_ms = now_ms;
         if (w.button == BtnPlus) begin
            plus_edge_ms = edge_ms;
            plus_act_ms  = act_ms;
         end else begin
            minus_edge_ms = edge_ms;
            minus_act_ms  = act_ms;
         end
      end else if (w.button == BtnSet) begin
         // with both edges only the press counts
         if (w.fall) begin
            if (reached(now_ms, set_edge_ms, deb) && !set_down) begin
               set_down     = 1'b1;
               long_hit     = 1'b0;
               set_down_ms  = now_ms;
               set_edge_ms  = now_ms;
               long_pending = 1'b1;
            end
         end else if (w.rise) begin
            if (reached(now_ms, set_edge_ms, deb)) begin
               set_edge_ms = now_ms;
               if (set_down) begin
                  // a short press opens the window or asks for a toggle
                  if (!long_hit) begin
                     if (!win_open)
                        touch_window();
                     else begin
                        toggle      = 1'b1;
                        activity_ms = now_ms;
                     end
                  end
                  long_pending = 1'b0;
                  set_down     = 1'b0;
                  long_hit     = 1'b0;
               end
            end
         end
      end
      s = '{row: cur_row, window_open: win_open, led_on: win_open && blink_on,
            toggle_request: toggle, clear_error: clear};
   endtask

   // offer one word from a falling edge, return at the falling edge after acceptance
   task automatic send_word(input btn_word_type w, input logic pinned);
      status_word_type s;
      if (!steady_run && $urandom_range(0, 7) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = w.cmd;
      req_tdata  = {4'd0, w.rise, w.fall, w.button};
      do @(posedge clock); while (!req_tready);
      predict_selector_word(w, s);
      expected_status_q.push_back(pinned ? IdleStatus : s);
      words_sent++;
      toggles_due += s.toggle_request;
      clears_due  += s.clear_error;
      @(negedge clock);
   endtask

   task automatic write_reg(input tbsw_pkg::csr_idx_type idx,
                            input logic [tbsw_pkg::CsrDataW-1:0] value);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = value;
      @(negedge clock);
   endtask

   // registers change only with the block drained
   task automatic load_timing(input timing_type t);
      req_tvalid = 1'b0;
      while (expected_status_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_reg(tbsw_pkg::CSR_DEBOUNCE, tbsw_pkg::CsrDataW'(t.debounce));
      write_reg(tbsw_pkg::CSR_GUARD,    tbsw_pkg::CsrDataW'(t.guard));
      write_reg(tbsw_pkg::CSR_LONG,     tbsw_pkg::CsrDataW'(t.long_press));
      write_reg(tbsw_pkg::CSR_BLINK,    tbsw_pkg::CsrDataW'(t.blink));
      write_reg(tbsw_pkg::CSR_WINDOW,   tbsw_pkg::CsrDataW'(t.window));
      write_reg(tbsw_pkg::CSR_PERIOD,   tbsw_pkg::CsrDataW'(t.period));
      csr_we = 1'b0;
      timing = t;
      settings_loaded++;
   endtask

   function automatic script_row_type script_row(input tbsw_pkg::cmd_type c,
                                                 input logic [1:0] b,
                                                 input logic f, input logic r,
                                                 input logic pinned);
      script_row_type sr;
      sr.w      = '{cmd: c, button: b, fall: f, rise: r};
      sr.pinned = pinned;
      return sr;
   endfunction

   // response side: random stall bursts plus one long hold-off
   initial begin
      int unsigned stall_left;
      bit          held_off;
      stall_left = 0;
      held_off   = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && results_seen >= HoldOffAt && !steady_run) begin
            held_off   = 1'b1;
            stall_left = HoldOffLen;
         end else if (stall_left == 0 && !steady_run && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 11);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else
            rsp_tready = 1'b1;
      end
   end

   // compare every accepted response with the oldest expectation
   always @(posedge clock) begin : check_response
      status_word_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{row: rsp_tdata[2:0], window_open: rsp_tdata[3], led_on: rsp_tdata[4],
                 toggle_request: rsp_tdata[5], clear_error: rsp_tdata[6]};
         results_seen++;
         if (expected_status_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReported)
               $display("%0t: response word %h with nothing expected", $time, rsp_tdata);
         end else begin
            want = expected_status_q.pop_front();
            if (got.row !== want.row || got.window_open !== want.window_open ||
                got.led_on !== want.led_on || got.toggle_request !== want.toggle_request ||
                got.clear_error !== want.clear_error) begin
               mismatches++;
               if (mismatches <= MaxReported) begin
                  $display("%0t: response %0d row/win/led/tgl/clr expected %0d %b %b %b %b",
                           $time, results_seen, want.row, want.window_open, want.led_on,
                           want.toggle_request, want.clear_error);
                  $display("%0t: response %0d row/win/led/tgl/clr got      %0d %b %b %b %b",
                           $time, results_seen, got.row, got.window_open, got.led_on,
                           got.toggle_request, got.clear_error);
               end
            end
         end
      end
   end

   // watchdog: nothing accepted on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stuck_cycles = 0;
      else begin
         stuck_cycles++;
         if (stuck_cycles >= StuckLimit) begin
            $display("%0t: no word moved for %0d cycles", $time, StuckLimit);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      script_row_type script[$];
      btn_word_type   gesture[$];
      btn_word_type   w;
      timing_type     t;
      int             phase_words[PhaseCount];
      int             sent_in_phase, kind, n, cap;
      logic [1:0]     b;

      phase_words = '{300, 40, 150, 300, 230};

      // predicted state after reset
      timing = '{debounce: tbsw_pkg::DebounceReset, guard: tbsw_pkg::GuardReset,
                 long_press: tbsw_pkg::LongReset, blink: tbsw_pkg::BlinkReset,
                 window: tbsw_pkg::WindowReset, period: tbsw_pkg::PeriodReset};
      now_ms       = '0;
      plus_edge_ms = '0;  plus_act_ms  = '0;
      minus_edge_ms = '0; minus_act_ms = '0;
      set_edge_ms  = '0;  set_down_ms  = '0;
      activity_ms  = '0;  blink_stamp_ms = '0;
      set_down = 1'b0; long_hit = 1'b0; long_pending = 1'b0;
      win_open = 1'b0; blink_on = 1'b0;
      cur_row  = '0;

      // directed rows on reset timing: nothing may get past debounce yet
      script.push_back(script_row(CmdTick, BtnPlus,   1'b0, 1'b0, 1'b1));
      script.push_back(script_row(CmdEdge, BtnPlus,   1'b1, 1'b0, 1'b1));
      script.push_back(script_row(CmdEdge, BtnUnused, 1'b1, 1'b1, 1'b1)); // unknown button
      script.push_back(script_row(CmdEdge, BtnMinus,  1'b0, 1'b0, 1'b1)); // no edge bits
      // fast timing from here on, zero check period
      script.push_back(script_row(CmdEdge, BtnPlus,   1'b1, 1'b0, 1'b0)); // opens window
      script.push_back(script_row(CmdEdge, BtnPlus,   1'b1, 1'b0, 1'b0)); // row up
      script.push_back(script_row(CmdEdge, BtnMinus,  1'b1, 1'b1, 1'b0)); // both edges
      script.push_back(script_row(CmdEdge, BtnMinus,  1'b1, 1'b0, 1'b0)); // wrap to top row
      script.push_back(script_row(CmdEdge, BtnPlus,   1'b1, 1'b0, 1'b0)); // wrap to row zero
      script.push_back(script_row(CmdTick, BtnPlus,   1'b0, 1'b0, 1'b0)); // blink flips
      script.push_back(script_row(CmdEdge, BtnSet,    1'b1, 1'b0, 1'b0));
      script.push_back(script_row(CmdEdge, BtnSet,    1'b0, 1'b1, 1'b0)); // short press, toggle
      script.push_back(script_row(CmdEdge, BtnSet,    1'b1, 1'b1, 1'b0)); // press only
      script.push_back(script_row(CmdEdge, BtnSet,    1'b1, 1'b0, 1'b0)); // repeated press
      repeat (3) script.push_back(script_row(CmdTick, BtnPlus, 1'b0, 1'b0, 1'b0));
      script.push_back(script_row(CmdEdge, BtnSet,    1'b0, 1'b1, 1'b0)); // after long press
      script.push_back(script_row(CmdEdge, BtnSet,    1'b0, 1'b1, 1'b0)); // stray release
      repeat (5) script.push_back(script_row(CmdTick, BtnPlus, 1'b0, 1'b0, 1'b0));
      script.push_back(script_row(CmdEdge, BtnSet,    1'b1, 1'b0, 1'b0));
      script.push_back(script_row(CmdEdge, BtnSet,    1'b0, 1'b1, 1'b0)); // short, opens

      repeat (2) @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) begin
         if (i == ResetRows) begin
            t = '{debounce: 16'd0, guard: 16'd0, long_press: 16'd3, blink: 16'd1,
                  window: 20'd6, period: 10'd0};
            load_timing(t);
         end
         send_word(script[i].w, script[i].pinned);
      end

      // random phases; every phase start drains the block before new timing
      for (int p = 0; p < PhaseCount; p++) begin
         case (p)
            1: t = '{debounce: 16'hFFFF, guard: 16'hFFFF, long_press: 16'hFFFF,
                     blink: 16'hFFFF, window: 20'hFFFFF, period: 10'd1023};
            2: t = '{debounce: 16'd0, guard: 16'd0, long_press: 16'd1, blink: 16'd1,
                     window: 20'd1, period: 10'd1};
            default: begin
               t.debounce   = 16'($urandom_range(0, 4));
               t.guard      = 16'($urandom_range(0, 8));
               t.long_press = 16'($urandom_range(1, 12));
               t.blink      = 16'($urandom_range(1, 6));
               t.window     = 20'($urandom_range(1, 40));
               t.period     = (p == 3) ? 10'd0 : 10'($urandom_range(1, 6));
            end
         endcase
         steady_run = (p == PhaseCount - 1);
         load_timing(t);
         cap = (t.long_press > 16'd28) ? 28 : int'(t.long_press);
         sent_in_phase = 0;
         while (sent_in_phase < phase_words[p]) begin
            gesture.delete();
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
               // tick run, now and then long enough to close the window
               n = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 6);
               repeat (n) gesture.push_back(TickWord);
            end else if (kind < 55) begin
               // plus or minus press and release
               b = 2'($urandom_range(0, 1));
               if ($urandom_range(0, 4) == 0)
                  gesture.push_back(btn_word_type'{cmd: CmdEdge, button: b,
                                                   fall: 1'b1, rise: 1'b1});
               else begin
                  gesture.push_back(btn_word_type'{cmd: CmdEdge, button: b,
                                                   fall: 1'b1, rise: 1'b0});
                  repeat ($urandom_range(0, 3)) gesture.push_back(TickWord);
                  gesture.push_back(btn_word_type'{cmd: CmdEdge, button: b,
                                                   fall: 1'b0, rise: 1'b1});
               end
            end else if (kind < 80) begin
               // set press held short or long; a long hold passes the long-press time only up to 28 ticks
               n = ($urandom_range(0, 2) == 0) ? $urandom_range(cap, cap + 3)
                                               : $urandom_range(0, cap - 1);
               gesture.push_back(btn_word_type'{cmd: CmdEdge, button: BtnSet,
                                                fall: 1'b1, rise: 1'b0});
               repeat (n) gesture.push_back(TickWord);
               gesture.push_back(btn_word_type'{cmd: CmdEdge, button: BtnSet,
                                                fall: 1'b0, rise: 1'b1});
            end else begin
               // noise: any field value, broken sequences
               repeat ($urandom_range(1, 3)) begin
                  w.cmd    = tbsw_pkg::cmd_type'($urandom_range(0, 1));
                  w.button = 2'($urandom_range(0, 3));
                  w.fall   = 1'($urandom_range(0, 1));
                  w.rise   = 1'($urandom_range(0, 1));
                  gesture.push_back(w);
               end
            end
            foreach (gesture[k]) send_word(gesture[k], 1'b0);
            sent_in_phase += gesture.size();
         end
      end

      req_tvalid = 1'b0;
      while (expected_status_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("covered %0d request words over %0d timing settings, %0d responses checked",
               words_sent, settings_loaded, results_seen);
      $display("saw %0d toggle and %0d error-clear requests, %0d mismatching responses",
               toggles_due, clears_due, mismatches);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/tbsw_pkg.sv
rtl/three_button_selector_with_window.sv
tb/sv/tb_three_button_selector_with_window.sv
